// ===== rtl/wtch_pkg.sv =====
// wtch_pkg: shared types and constants of the whitespace token classifier
// holds the token state record, the result record and the fnv-1a constants
// no dependencies
`timescale 1ns / 1ps

package wtch_pkg;

    // fnv-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // character bounds
    localparam logic [7:0] SEP_MAX    = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7a;

    // token length saturation point
    localparam logic [15:0] LEN_LIMIT = 16'hffff;

    // token class codes
    typedef enum logic [1:0] {
        CLS_NUMBER     = 2'd0,
        CLS_IDENTIFIER = 2'd1,
        CLS_UNKNOWN    = 2'd2
    } t_class;

    // state of the open token
    typedef struct packed {
        logic        active;
        logic        digits;
        logic        letters;
        logic [31:0] hash;
        logic [15:0] start;
        logic [15:0] length;
    } t_tok_state;

    // one result item plus its valid flag
    typedef struct packed {
        logic        valid;
        t_class      cls;
        logic [31:0] hash;
        logic [15:0] start;
        logic [15:0] length;
        logic        closes;
    } t_tok_result;

    // state right after reset or after a token closes
    localparam t_tok_state TOK_CLEAR = '{
        active:  1'b0,
        digits:  1'b1,
        letters: 1'b1,
        hash:    FNV_BASIS,
        start:   16'd0,
        length:  16'd0
    };

endpackage

// ===== rtl/wtch_in_stage.sv =====
// wtch_in_stage: input register of the token classifier
// holds one source byte and its chunk end flag until the core takes it
// depends on nothing but the handshake from the top level
`timescale 1ns / 1ps

module wtch_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_source_byte,
    input  logic       i_chunk_end,
    input  logic       i_advance,
    output logic       o_busy,
    output logic [7:0] o_byte,
    output logic       o_end
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       w_load;

    // room when empty or when the held item moves on this cycle
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    // valid flag
    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_source_byte;
            r_end  <= i_chunk_end;
        end
    end

    assign o_busy = r_valid;
    assign o_byte = r_byte;
    assign o_end  = r_end;

endmodule

// ===== rtl/wtch_token_step.sv =====
// wtch_token_step: per-byte token update and result formation
// combinational: classifies the byte, steps the fnv-1a hash, closes tokens
// depends on wtch_pkg
`timescale 1ns / 1ps

module wtch_token_step (
    input  wtch_pkg::t_tok_state  i_state,
    input  logic [15:0]           i_position,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output wtch_pkg::t_tok_state  o_state,
    output wtch_pkg::t_tok_result o_result
);

    logic                 w_sep;
    logic                 w_dig;
    logic                 w_let;
    logic                 w_ends;
    logic [31:0]          w_mix;
    logic [31:0]          w_hash;
    wtch_pkg::t_tok_state w_abs;

    // byte classification
    assign w_sep  = (i_byte <= wtch_pkg::SEP_MAX);
    assign w_dig  = (i_byte >= wtch_pkg::CHAR_ZERO) && (i_byte <= wtch_pkg::CHAR_NINE);
    assign w_let  = ((i_byte >= wtch_pkg::CHAR_UP_A) && (i_byte <= wtch_pkg::CHAR_UP_Z)) ||
                    ((i_byte >= wtch_pkg::CHAR_LOW_A) && (i_byte <= wtch_pkg::CHAR_LOW_Z));
    assign w_ends = w_sep || i_end;

    // fnv-1a step, product kept modulo 2^32
    assign w_mix  = i_state.hash ^ {24'd0, i_byte};
    assign w_hash = w_mix * wtch_pkg::FNV_PRIME;

    // absorb a non-separator byte into the open token
    always_comb begin
        w_abs = i_state;
        if (!w_sep) begin
            w_abs.active  = 1'b1;
            w_abs.digits  = i_state.digits && w_dig;
            w_abs.letters = i_state.letters && w_let;
            w_abs.hash    = w_hash;
            if (!i_state.active) begin
                w_abs.start  = i_position;
                w_abs.length = 16'd1;
            end else if (i_state.length < wtch_pkg::LEN_LIMIT) begin
                w_abs.length = i_state.length + 16'd1;
            end
        end
    end

    // next token state
    assign o_state = w_ends ? wtch_pkg::TOK_CLEAR : w_abs;

    // result of a closing token
    always_comb begin
        o_result.valid  = w_ends && w_abs.active && (w_abs.length != 16'd0);
        o_result.hash   = 32'd0;
        o_result.start  = w_abs.start;
        o_result.length = w_abs.length;
        o_result.closes = i_end;
        if (w_abs.digits) begin
            o_result.cls = wtch_pkg::CLS_NUMBER;
        end else if (w_abs.letters) begin
            o_result.cls  = wtch_pkg::CLS_IDENTIFIER;
            o_result.hash = w_abs.hash;
        end else begin
            o_result.cls = wtch_pkg::CLS_UNKNOWN;
        end
    end

endmodule

// ===== rtl/whitespace_token_classifier_hash.sv =====
// Whitespace tokenizer with a 32-bit FNV-1a hash over each token. One source
// byte is taken per item; bytes at or below 0x20 separate tokens and the byte
// flagged chunk_end also closes the open token and restarts offsets at zero.
// Each closed non-empty token gives one result: class, hash (identifiers only),
// start offset and length, both saturating. The block takes one item every
// cycle unless input stalls: an input register feeds a single combinational
// step (compares plus one 32x32 constant multiply for the hash) into a result
// register, which offers the result of a closing byte, and input stalls only
// while a finished result is held by a stalled output.
// Depends on wtch_pkg, wtch_in_stage and wtch_token_step.
`timescale 1ns / 1ps

module whitespace_token_classifier_hash #(
    parameter int MAX_CHUNK_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    input  logic        i_chunk_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_token_class,
    output logic [31:0] o_token_hash,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_closes_chunk
);

    localparam int          POS_LIMIT_INT = (MAX_CHUNK_BYTES - 1 < 65535) ?
                                            (MAX_CHUNK_BYTES - 1) : 65535;
    localparam logic [15:0] POS_LIMIT     = 16'(POS_LIMIT_INT);

    logic                  w_busy;
    logic [7:0]            w_byte;
    logic                  w_end;
    logic                  w_advance;
    wtch_pkg::t_tok_state  r_state;
    wtch_pkg::t_tok_state  n_state;
    wtch_pkg::t_tok_result w_result;
    logic [15:0]           r_position;
    logic [15:0]           n_position;
    logic                  r_out_valid;
    logic                  n_out_valid;
    wtch_pkg::t_tok_result r_out;

    // core moves when it holds an item and the result slot is free or being taken
    assign w_advance = w_busy && (!r_out_valid || !i_stall);

    wtch_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_source_byte (i_source_byte),
        .i_chunk_end   (i_chunk_end),
        .i_advance     (w_advance),
        .o_busy        (w_busy),
        .o_byte        (w_byte),
        .o_end         (w_end)
    );

    wtch_token_step u_token_step (
        .i_state    (r_state),
        .i_position (r_position),
        .i_byte     (w_byte),
        .i_end      (w_end),
        .o_state    (n_state),
        .o_result   (w_result)
    );

    // byte position within the chunk, saturating
    always_comb begin
        n_position = r_position;
        if (w_end) begin
            n_position = 16'd0;
        end else if (r_position < POS_LIMIT) begin
            n_position = r_position + 16'd1;
        end
    end

    // token state and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wtch_pkg::TOK_CLEAR;
            r_position <= 16'd0;
        end else if (w_advance) begin
            r_state    <= n_state;
            r_position <= n_position;
        end
    end

    // result slot valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = w_result.valid;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_token_class  = r_out.cls;
    assign o_token_hash   = r_out.hash;
    assign o_start_offset = r_out.start;
    assign o_token_length = r_out.length;
    assign o_closes_chunk = r_out.closes;

    // a held result is never empty
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_length != 16'd0))
        else $error("result with zero token length");

    // hash only travels with identifiers
    a_hash_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_class != wtch_pkg::CLS_IDENTIFIER)) |-> (o_token_hash == 32'd0))
        else $error("nonzero hash on a non-identifier token");

    // an open token always has a length
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> (r_state.length != 16'd0))
        else $error("open token with zero length");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench of the whitespace token classifier
// drives byte items, predicts each closed token and compares every result field
// depends on wtch_pkg and whitespace_token_classifier_hash
`timescale 1ns / 1ps

module tb_top;

    // run shape
    localparam int CHUNK_BYTES  = 65536;
    localparam int RANDOM_ITEMS = 1875;
    localparam int QUIET_FROM   = 1650;
    localparam int RUN_LIMIT    = 400000;

    // hash and saturation constants
    localparam logic [31:0] HASH_BASIS = 32'h811c9dc5;
    localparam logic [31:0] HASH_PRIME = 32'h01000193;
    localparam logic [15:0] LEN_CAP    = 16'hffff;
    localparam logic [15:0] POS_CAP    =
        (CHUNK_BYTES - 1 < 65535) ? 16'(CHUNK_BYTES - 1) : 16'hffff;

    // kinds of token content for random chunks
    typedef enum int {
        KIND_DIGITS,
        KIND_LETTERS,
        KIND_ALNUM,
        KIND_ANY
    } t_kind;

    // directed items: {chunk_end, byte}
    localparam logic [8:0] DIRECTED_ITEMS [25] = '{
        {1'b0, 8'h30}, {1'b0, 8'h39}, {1'b0, 8'h20},
        {1'b0, 8'h41}, {1'b0, 8'h5a}, {1'b0, 8'h61}, {1'b0, 8'h7a}, {1'b0, 8'h00},
        {1'b0, 8'h2f}, {1'b0, 8'h3a}, {1'b0, 8'h40}, {1'b0, 8'h5b},
        {1'b0, 8'h60}, {1'b0, 8'h7b}, {1'b0, 8'h20},
        {1'b0, 8'h21}, {1'b1, 8'hff},
        {1'b0, 8'h78}, {1'b0, 8'h31}, {1'b1, 8'h20},
        {1'b1, 8'h20},
        {1'b1, 8'h37},
        {1'b0, 8'h1f}, {1'b0, 8'h20},
        {1'b0, 8'h71}
    };

    // token tracking: predicts results from accepted bytes and checks them
    class token_tracker;
        typedef struct {
            wtch_pkg::t_class cls;
            logic [31:0]      hash;
            logic [15:0]      start;
            logic [15:0]      length;
            logic             closes;
        } t_token;

        t_token      expected_tokens[$];
        int          failures;
        bit          in_token;
        bit          digits;
        bit          letters;
        logic [31:0] hash;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] position;

        function new();
            failures = 0;
            position = '0;
            clear_token();
        endfunction

        function void clear_token();
            in_token = 1'b0;
            digits   = 1'b1;
            letters  = 1'b1;
            hash     = HASH_BASIS;
            start    = '0;
            length   = '0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_token tok;
            bit     is_sep;
            bit     is_digit;
            bit     is_letter;
            is_sep    = (b <= 8'h20);
            is_digit  = (b >= 8'h30 && b <= 8'h39);
            is_letter = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
            // a non-separator joins the open token, the last byte of a chunk too
            if (!is_sep) begin
                if (!in_token) begin
                    in_token = 1'b1;
                    start    = position;
                    length   = '0;
                end
                digits  = digits && is_digit;
                letters = letters && is_letter;
                hash    = (hash ^ {24'd0, b}) * HASH_PRIME;
                if (length != LEN_CAP) length++;
            end
            // a separator or the chunk end closes the token
            if (is_sep || last) begin
                if (in_token && length != 0) begin
                    tok.cls    = digits ? wtch_pkg::CLS_NUMBER :
                                 (letters ? wtch_pkg::CLS_IDENTIFIER : wtch_pkg::CLS_UNKNOWN);
                    tok.hash   = (!digits && letters) ? hash : 32'd0;
                    tok.start  = start;
                    tok.length = length;
                    tok.closes = last;
                    expected_tokens = {expected_tokens, tok};
                end
                clear_token();
            end
            // offset restarts at chunk end, saturates otherwise
            if (last) position = '0;
            else if (position < POS_CAP) position++;
        endfunction

        function void check_token(logic [1:0] cls, logic [31:0] h, logic [15:0] st,
                                  logic [15:0] len, logic closes);
            t_token want;
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: class %0d start %0d length %0d",
                       cls, st, len);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            if (cls !== want.cls) begin
                $error("token_class: expected %0d, got %0d", want.cls, cls);
                failures++;
            end
            if (h !== want.hash) begin
                $error("token_hash: expected %08h, got %08h", want.hash, h);
                failures++;
            end
            if (st !== want.start) begin
                $error("start_offset: expected %0d, got %0d", want.start, st);
                failures++;
            end
            if (len !== want.length) begin
                $error("token_length: expected %0d, got %0d", want.length, len);
                failures++;
            end
            if (closes !== want.closes) begin
                $error("closes_chunk: expected %0d, got %0d", want.closes, closes);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_source_byte;
    logic        i_chunk_end;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_token_class;
    logic [31:0] o_token_hash;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic        o_closes_chunk;

    token_tracker tracker = new();
    int           gap_odds = 4;
    bit           quiet = 1'b0;
    int           cycle_count;

    whitespace_token_classifier_hash #(
        .MAX_CHUNK_BYTES(CHUNK_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_source_byte  (i_source_byte),
        .i_chunk_end    (i_chunk_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_class  (o_token_class),
        .o_token_hash   (o_token_hash),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_closes_chunk (o_closes_chunk)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watch both channels at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) tracker.note_byte(i_source_byte, i_chunk_end);
            if (o_valid && !i_stall) begin
                tracker.check_token(o_token_class, o_token_hash, o_start_offset,
                                    o_token_length, o_closes_chunk);
            end
        end
    end

    // overall timeout
    initial begin
        for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // output stall bursts until the quiet tail
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        while (!quiet) begin
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (quiet) break;
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // random content byte of a token
    function automatic logic [7:0] token_byte(t_kind kind);
        int pick;
        pick = $urandom_range(0, 61);
        case (kind)
            KIND_DIGITS: begin
                return 8'(8'h30 + pick % 10);
            end
            KIND_LETTERS, KIND_ALNUM: begin
                if (kind == KIND_ALNUM && pick < 10) return 8'(8'h30 + pick);
                pick = pick % 52;
                return (pick < 26) ? 8'(8'h41 + pick) : 8'(8'h61 + pick - 26);
            end
            default: begin
                return 8'($urandom_range(33, 255));
            end
        endcase
    endfunction

    // offer one item, with an occasional idle burst before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_source_byte <= b;
        i_chunk_end   <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // hold off input until every pending token has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [8:0] chunk_items [$];
        logic [8:0] entry;
        int         items_sent;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_source_byte <= 8'h00;
        i_chunk_end   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: class borders, separators, chunk end on both byte kinds
        foreach (DIRECTED_ITEMS[k]) send_byte(DIRECTED_ITEMS[k][7:0], DIRECTED_ITEMS[k][8]);
        drain();

        // random chunks: mostly well-formed token runs, some noise
        gap_odds   = 4;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            chunk_items.delete();
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 24)) begin
                    entry       = {1'($urandom_range(7) == 0), 8'($urandom)};
                    chunk_items = {chunk_items, entry};
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    repeat ($urandom_range(0, 2)) begin
                        entry       = {1'b0, 8'($urandom_range(0, 32))};
                        chunk_items = {chunk_items, entry};
                    end
                    repeat (($urandom_range(7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8)) begin
                        entry       = {1'b0, token_byte(t_kind'($urandom_range(0, 3)))};
                        chunk_items = {chunk_items, entry};
                    end
                    entry       = {1'b0, 8'($urandom_range(0, 32))};
                    chunk_items = {chunk_items, entry};
                end
                // sometimes the chunk ends on a token byte
                if ($urandom_range(2) == 0) void'(chunk_items.pop_back());
                chunk_items[chunk_items.size() - 1][8] = 1'b1;
            end
            foreach (chunk_items[k]) begin
                if (items_sent >= QUIET_FROM) begin
                    quiet    = 1'b1;
                    gap_odds = 0;
                end
                send_byte(chunk_items[k][7:0], chunk_items[k][8]);
                items_sent++;
            end
        end
        drain();

        if (tracker.failures == 0 && tracker.expected_tokens.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
